// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check b in the cycle after a
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

// check b in the same cycle as a
`define ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/m2acc_pkg.sv -----
// Shared types and constants of the 2x2 matrix accumulator unit.
// No dependencies.
package m2acc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int S_DATA_W      = 224;
	localparam int S_USER_W      = 4;
	localparam int M_DATA_W      = 232;
	localparam int CFG_W         = 16;
	localparam int CFG_ADDR_W    = 1;

	localparam int FLAG_EXACT    = 224;
	localparam int FLAG_NEAR     = 225;

	localparam logic [CFG_ADDR_W-1:0] REG_COORD_TOL = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DET_TOL   = 1'd1;

	typedef enum logic [3:0] {
		ACT_LOAD      = 4'd0,
		ACT_ADD       = 4'd1,
		ACT_SUB       = 4'd2,
		ACT_POSTMUL   = 4'd3,
		ACT_PREMUL    = 4'd4,
		ACT_SCALE     = 4'd5,
		ACT_TRANSPOSE = 4'd6,
		ACT_INVERT    = 4'd7,
		ACT_IDENTITY  = 4'd8,
		ACT_COMPARE   = 4'd9,
		ACT_VECTOR    = 4'd10
	} act_t;

endpackage

// ----- rtl/core/matrix2x2_accumulator_alu_unit.sv -----
// Channel | dir | content
// s_axis  | in  | tuser: action; tdata: operand 11,12,21,22, scale, vec x, vec y
// m_axis  | out | tdata: acc 11,12,21,22, det, vec x, vec y, flags
// cfg     | in  | index 0 coord tolerance, index 1 det tolerance
//
// One multiplier, shared: each product sum passes S_MUL and S_ACC for each of its two products, then S_RND.
// Load/add/sub/transpose/identity/compare/vector: S_SIMPLE, then the det, vec x and vec y product sums, then S_FLAGS.
// Post-multiply, pre-multiply, scale: one product sum per element, then the det, vec x and vec y product sums.
// Invert: determinant product sum, then a bit-serial divider per element (S_DLOAD, S_DIV, S_DFIN); singular skips it.
// arst_n clears the accumulator and sets both tolerances to 16.
// s_axis_tready is high only while idle; a held result does not block the next accept.
//
// Top level of the 2x2 matrix accumulator unit; depends on m2acc_pkg.
module matrix2x2_accumulator_alu_unit #(
	parameter int FRAC_BITS = m2acc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// operand_11, operand_12, operand_21, operand_22, scale_factor, vec_in_x, vec_in_y
	input  logic [m2acc_pkg::S_DATA_W-1:0]      s_axis_tdata,
	// action
	input  logic [m2acc_pkg::S_USER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// acc_11, acc_12, acc_21, acc_22, det_value, vec_out_x, vec_out_y,
	// exact_equal, near_equal, is_identity, singular, saturated, zero fill
	output logic [m2acc_pkg::M_DATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [m2acc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [m2acc_pkg::CFG_W-1:0]         cfg_wdata
);
	import m2acc_pkg::*;

	localparam int SW   = 66;
	localparam int DETW = SW - FRAC_BITS;
	localparam int DW   = 32 + FRAC_BITS;
	localparam int CW   = $clog2(DW);
	localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
	localparam logic [31:0] ONE  = 32'(1) << FRAC_BITS;
	localparam logic [DW-1:0] QLIM = DW'(64'h8000_0000);
	localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV = 32'h8000_0000;

	typedef enum logic [3:0] {
		S_IDLE, S_SIMPLE, S_MUL, S_ACC, S_RND, S_DCHK, S_DLOAD, S_DIV, S_DFIN, S_FLAGS
	} state_t;

	typedef enum logic [1:0] {PH_MAIN, PH_DET, PH_POST} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [1:0] j_q, e_q;
	logic k_q;
	logic [CW-1:0] cnt_q;
	logic m_valid_q;
	logic [M_DATA_W-1:0] out_q;
	logic [31:0] acc_q [4];
	logic [CFG_W-1:0] ctol_q, dtol_q;
	logic sat_q, sing_q;

	act_t act_q;
	logic [31:0] op_q [4];
	logic [31:0] n_q [4];
	logic [31:0] s_q, vx_q, vy_q;
	logic signed [63:0] prod_q;
	logic signed [SW-1:0] sum_q;
	logic signed [DETW-1:0] det_q;
	logic [DETW-1:0] dmag_q, rem_q;
	logic dneg_q;
	logic [DW-1:0] quo_q;
	logic [31:0] det_out_q, vox_q, voy_q;

	logic signed [31:0] mul_x, mul_y;
	logic signed [63:0] prod;
	logic mac_sub;
	logic signed [SW-1:0] pext, rsum, rnd;
	logic [SW-32:0] rnd_hi;
	logic rnd_ovf;
	logic [31:0] rnd_clip;
	logic [31:0] as_val [4];
	logic as_ovf [4];
	logic [DETW-1:0] dmag;
	logic [32:0] num33;
	logic [31:0] nmag;
	logic [DETW:0] trial, diff;
	logic ge;
	logic q_ovf;
	logic [31:0] q_val;
	logic [32:0] fd [4];
	logic [32:0] fabs [4];
	logic f_exact, f_near, f_ident;
	logic out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	always_comb begin
		mul_x = '0;
		mul_y = '0;
		mac_sub = 1'b0;
		case (phase_q)
			PH_MAIN: begin
				case (act_q)
					ACT_POSTMUL: begin
						mul_x = acc_q[{j_q[1], k_q}];
						mul_y = op_q[{k_q, j_q[0]}];
					end
					ACT_PREMUL: begin
						mul_x = op_q[{j_q[1], k_q}];
						mul_y = acc_q[{k_q, j_q[0]}];
					end
					default: begin
						if (!k_q) begin
							mul_x = acc_q[j_q];
							mul_y = s_q;
						end
					end
				endcase
			end
			PH_DET: begin
				mul_x = k_q ? acc_q[1] : acc_q[0];
				mul_y = k_q ? acc_q[2] : acc_q[3];
				mac_sub = 1'b1;
			end
			default: begin
				case (j_q)
					2'd0: begin
						mul_x = k_q ? n_q[1] : n_q[0];
						mul_y = k_q ? n_q[2] : n_q[3];
						mac_sub = 1'b1;
					end
					2'd1: begin
						mul_x = k_q ? n_q[1] : n_q[0];
						mul_y = k_q ? vy_q : vx_q;
					end
					default: begin
						mul_x = k_q ? n_q[3] : n_q[2];
						mul_y = k_q ? vy_q : vx_q;
					end
				endcase
			end
		endcase
	end

	assign prod = mul_x * mul_y;
	assign pext = {{(SW-64){prod_q[63]}}, prod_q};
	assign rsum = sum_q + HALF;
	assign rnd  = rsum >>> FRAC_BITS;
	assign rnd_hi = rnd[SW-1:31];
	assign rnd_ovf = !((&rnd_hi) || !(|rnd_hi));
	assign rnd_clip = rnd_ovf ? (rnd[SW-1] ? MINV : MAXV) : rnd[31:0];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic [32:0] t;
			if (act_q == ACT_SUB)
				t = {acc_q[i][31], acc_q[i]} - {op_q[i][31], op_q[i]};
			else
				t = {acc_q[i][31], acc_q[i]} + {op_q[i][31], op_q[i]};
			as_ovf[i] = t[32] != t[31];
			as_val[i] = as_ovf[i] ? (t[32] ? MINV : MAXV) : t[31:0];
		end
	end

	assign dmag = det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);

	always_comb begin
		case (e_q)
			2'd0: num33 = {acc_q[3][31], acc_q[3]};
			2'd1: num33 = -{acc_q[1][31], acc_q[1]};
			2'd2: num33 = -{acc_q[2][31], acc_q[2]};
			default: num33 = {acc_q[0][31], acc_q[0]};
		endcase
	end
	assign nmag = num33[32] ? 32'(-num33) : num33[31:0];

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, dmag_q};
	assign diff  = trial - {1'b0, dmag_q};

	assign q_ovf = dneg_q ? (quo_q > QLIM) : (quo_q >= QLIM);
	assign q_val = q_ovf ? (dneg_q ? MINV : MAXV) : (dneg_q ? -quo_q[31:0] : quo_q[31:0]);

	always_comb begin
		f_exact = 1'b1;
		f_near  = 1'b1;
		for (int i = 0; i < 4; i++) begin
			fd[i] = {n_q[i][31], n_q[i]} - {op_q[i][31], op_q[i]};
			fabs[i] = fd[i][32] ? -fd[i] : fd[i];
			if (fd[i] != '0)
				f_exact = 1'b0;
			if (fabs[i] > {17'd0, ctol_q})
				f_near = 1'b0;
		end
		f_ident = (n_q[0] == ONE) && (n_q[1] == '0) && (n_q[2] == '0) && (n_q[3] == ONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_MAIN;
			j_q       <= '0;
			k_q       <= 1'b0;
			e_q       <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
			out_q     <= '0;
			ctol_q    <= CFG_W'(16);
			dtol_q    <= CFG_W'(16);
			sat_q     <= 1'b0;
			sing_q    <= 1'b0;
			for (int i = 0; i < 4; i++)
				acc_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_COORD_TOL: ctol_q <= cfg_wdata;
					REG_DET_TOL:   dtol_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (m_valid_q && m_axis_tready && state_q != S_FLAGS)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						sat_q  <= 1'b0;
						sing_q <= 1'b0;
						j_q    <= '0;
						k_q    <= 1'b0;
						e_q    <= '0;
						case (act_t'(s_axis_tuser))
							ACT_POSTMUL, ACT_PREMUL, ACT_SCALE: begin
								phase_q <= PH_MAIN;
								state_q <= S_MUL;
							end
							ACT_INVERT: begin
								phase_q <= PH_DET;
								state_q <= S_MUL;
							end
							default: state_q <= S_SIMPLE;
						endcase
					end
				end
				S_SIMPLE: begin
					if (act_q == ACT_ADD || act_q == ACT_SUB)
						sat_q <= as_ovf[0] | as_ovf[1] | as_ovf[2] | as_ovf[3];
					phase_q <= PH_POST;
					j_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					k_q     <= ~k_q;
					state_q <= k_q ? S_RND : S_MUL;
				end
				S_RND: begin
					case (phase_q)
						PH_MAIN: begin
							sat_q <= sat_q | rnd_ovf;
							if (j_q == 2'd3) begin
								phase_q <= PH_POST;
								j_q     <= '0;
							end else begin
								j_q <= j_q + 2'd1;
							end
							state_q <= S_MUL;
						end
						PH_DET: state_q <= S_DCHK;
						default: begin
							if (j_q != 2'd0)
								sat_q <= sat_q | rnd_ovf;
							if (j_q == 2'd2) begin
								state_q <= S_FLAGS;
							end else begin
								j_q     <= j_q + 2'd1;
								state_q <= S_MUL;
							end
						end
					endcase
				end
				S_DCHK: begin
					if (det_q == '0 || dmag < DETW'(dtol_q)) begin
						sing_q  <= 1'b1;
						phase_q <= PH_POST;
						j_q     <= '0;
						state_q <= S_MUL;
					end else begin
						e_q     <= '0;
						state_q <= S_DLOAD;
					end
				end
				S_DLOAD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW - 1))
						state_q <= S_DFIN;
				end
				S_DFIN: begin
					sat_q <= sat_q | q_ovf;
					if (e_q == 2'd3) begin
						phase_q <= PH_POST;
						j_q     <= '0;
						state_q <= S_MUL;
					end else begin
						e_q     <= e_q + 2'd1;
						state_q <= S_DLOAD;
					end
				end
				S_FLAGS: begin
					if (out_free) begin
						out_q <= {3'd0, sat_q, sing_q, f_ident, f_near, f_exact,
							voy_q, vox_q, det_out_q, n_q[3], n_q[2], n_q[1], n_q[0]};
						m_valid_q <= 1'b1;
						for (int i = 0; i < 4; i++)
							acc_q[i] <= n_q[i];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					act_q <= act_t'(s_axis_tuser);
					for (int i = 0; i < 4; i++) begin
						op_q[i] <= s_axis_tdata[32*i +: 32];
						n_q[i]  <= acc_q[i];
					end
					s_q  <= s_axis_tdata[128 +: 32];
					vx_q <= s_axis_tdata[160 +: 32];
					vy_q <= s_axis_tdata[192 +: 32];
				end
			end
			S_SIMPLE: begin
				case (act_q)
					ACT_LOAD: begin
						for (int i = 0; i < 4; i++)
							n_q[i] <= op_q[i];
					end
					ACT_ADD, ACT_SUB: begin
						for (int i = 0; i < 4; i++)
							n_q[i] <= as_val[i];
					end
					ACT_TRANSPOSE: begin
						n_q[1] <= acc_q[2];
						n_q[2] <= acc_q[1];
					end
					ACT_IDENTITY: begin
						n_q[0] <= ONE;
						n_q[1] <= '0;
						n_q[2] <= '0;
						n_q[3] <= ONE;
					end
					default: ;
				endcase
			end
			S_MUL: prod_q <= prod;
			S_ACC: begin
				if (!k_q)
					sum_q <= pext;
				else if (mac_sub)
					sum_q <= sum_q - pext;
				else
					sum_q <= sum_q + pext;
			end
			S_RND: begin
				case (phase_q)
					PH_MAIN: n_q[j_q] <= rnd_clip;
					PH_DET:  det_q <= rnd[DETW-1:0];
					default: begin
						case (j_q)
							2'd0: det_out_q <= rnd_clip;
							2'd1: vox_q <= rnd_clip;
							default: voy_q <= rnd_clip;
						endcase
					end
				endcase
			end
			S_DCHK: dmag_q <= dmag;
			S_DLOAD: begin
				rem_q  <= '0;
				quo_q  <= {nmag, {FRAC_BITS{1'b0}}};
				dneg_q <= num33[32] ^ det_q[DETW-1];
			end
			S_DIV: begin
				rem_q <= ge ? diff[DETW-1:0] : trial[DETW-1:0];
				quo_q <= {quo_q[DW-2:0], ge};
			end
			S_DFIN: n_q[e_q] <= q_val;
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/m2acc_checker.sv -----
// Port-level checker for the 2x2 matrix accumulator unit, bound to the top level.
// Depends on m2acc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module m2acc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [m2acc_pkg::M_DATA_W-1:0] m_axis_tdata
);
	import m2acc_pkg::*;

	`ASSERT_NEXT(a_hold_result, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`ASSERT_NEXT(a_busy_after_beat, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`ASSERT_SAME(a_exact_is_near, clk, arst_n, m_axis_tvalid && m_axis_tdata[FLAG_EXACT], m_axis_tdata[FLAG_NEAR])
	`ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind matrix2x2_accumulator_alu_unit m2acc_checker u_m2acc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb.sv -----
// Self-checking testbench of the 2x2 matrix accumulator unit (matrix2x2_accumulator_alu_unit).
// Predicts every result beat from its own fixed-point model; depends on m2acc_pkg.
`timescale 1ns / 100ps

module tb;
	import m2acc_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;
	localparam longint LIMIT = 4000000;

	typedef struct packed {
		logic [31:0] vy, vx, sc, o22, o21, o12, o11;
	} op_beat_t;

	typedef struct {
		act_t act;
		op_beat_t d;
	} cmd_t;

	typedef struct {
		logic [31:0] a11, a12, a21, a22, det, vox, voy;
		logic ex, nr, id, sg, st;
	} mres_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic [S_USER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic cfg_we = 0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	cmd_t pending_cmds[$];
	mres_t expected_results[$];
	longint mat[4];
	longint coord_tol, det_tol;
	int errors = 0, beats_in = 0, beats_out = 0;
	int send_idle = 0, recv_stall = 0;
	int hold_off = 0;
	longint cycles = 0;

	matrix2x2_accumulator_alu_unit i_dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic longint clip(longint v, ref bit f);
		if (v > 64'sd2147483647) begin
			f = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// round-half-up of (a*b + c*d) / 2^FB, exact in 128 bits
	function automatic longint rmac(longint a, longint b, longint c, longint d);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b) + 128'(c) * 128'(d) + (128'sd1 <<< (FB - 1));
		return longint'(p >>> FB);
	endfunction

	function automatic mres_t apply_action(cmd_t c);
		longint op[4], n[4], a[4], dt, mg, dd;
		bit sat, sing, dmy;
		mres_t r;
		sat = 0; sing = 0; dmy = 0;
		op[0] = longint'(signed'(c.d.o11)); op[1] = longint'(signed'(c.d.o12));
		op[2] = longint'(signed'(c.d.o21)); op[3] = longint'(signed'(c.d.o22));
		for (int i = 0; i < 4; i++) begin
			a[i] = mat[i];
			n[i] = a[i];
		end
		case (c.act)
			ACT_LOAD: for (int i = 0; i < 4; i++) n[i] = op[i];
			ACT_ADD: for (int i = 0; i < 4; i++) n[i] = clip(a[i] + op[i], sat);
			ACT_SUB: for (int i = 0; i < 4; i++) n[i] = clip(a[i] - op[i], sat);
			ACT_POSTMUL: begin
				n[0] = clip(rmac(a[0], op[0], a[1], op[2]), sat);
				n[1] = clip(rmac(a[0], op[1], a[1], op[3]), sat);
				n[2] = clip(rmac(a[2], op[0], a[3], op[2]), sat);
				n[3] = clip(rmac(a[2], op[1], a[3], op[3]), sat);
			end
			ACT_PREMUL: begin
				n[0] = clip(rmac(op[0], a[0], op[1], a[2]), sat);
				n[1] = clip(rmac(op[0], a[1], op[1], a[3]), sat);
				n[2] = clip(rmac(op[2], a[0], op[3], a[2]), sat);
				n[3] = clip(rmac(op[2], a[1], op[3], a[3]), sat);
			end
			ACT_SCALE: for (int i = 0; i < 4; i++)
				n[i] = clip(rmac(a[i], longint'(signed'(c.d.sc)), 0, 0), sat);
			ACT_TRANSPOSE: begin
				n[1] = a[2];
				n[2] = a[1];
			end
			ACT_INVERT: begin
				dt = rmac(a[0], a[3], a[1], -a[2]);
				mg = dt < 0 ? -dt : dt;
				if (dt == 0 || mg < det_tol) sing = 1;
				else begin
					n[0] = clip((a[3] * ONE) / dt, sat);
					n[1] = clip((-a[1] * ONE) / dt, sat);
					n[2] = clip((-a[2] * ONE) / dt, sat);
					n[3] = clip((a[0] * ONE) / dt, sat);
				end
			end
			ACT_IDENTITY: begin
				n[0] = ONE; n[1] = 0; n[2] = 0; n[3] = ONE;
			end
			default: ;
		endcase
		r.ex = 1; r.nr = 1;
		for (int i = 0; i < 4; i++) begin
			dd = n[i] - op[i];
			if (dd < 0) dd = -dd;
			mat[i] = n[i];
			if (dd != 0) r.ex = 0;
			if (dd > coord_tol) r.nr = 0;
		end
		r.id = n[0] == ONE && n[1] == 0 && n[2] == 0 && n[3] == ONE;
		r.det = 32'(clip(rmac(n[0], n[3], n[1], -n[2]), dmy));
		r.vox = 32'(clip(rmac(n[0], longint'(signed'(c.d.vx)), n[1],
			longint'(signed'(c.d.vy))), sat));
		r.voy = 32'(clip(rmac(n[2], longint'(signed'(c.d.vx)), n[3],
			longint'(signed'(c.d.vy))), sat));
		r.a11 = 32'(n[0]); r.a12 = 32'(n[1]); r.a21 = 32'(n[2]); r.a22 = 32'(n[3]);
		r.sg = sing;
		r.st = sat;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %h expected %h", beats_out, what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			beats_in++;
			expected_results.push_back(apply_action(pending_cmds.pop_front()));
		end
		if (!(s_axis_tvalid && !s_axis_tready)) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle
				&& !(s_axis_tvalid && s_axis_tready && pending_cmds.size() == 0)) begin
				s_axis_tvalid <= 1;
				s_axis_tdata <= pending_cmds[0].d;
				s_axis_tuser <= pending_cmds[0].act;
			end else
				s_axis_tvalid <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		mres_t w;
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout");
			$display("simulation failed");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$display("unexpected result beat");
				errors++;
			end else begin
				w = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== w.a11) report_mismatch("acc_11", m_axis_tdata[31:0], w.a11);
				if (m_axis_tdata[63:32] !== w.a12) report_mismatch("acc_12", m_axis_tdata[63:32], w.a12);
				if (m_axis_tdata[95:64] !== w.a21) report_mismatch("acc_21", m_axis_tdata[95:64], w.a21);
				if (m_axis_tdata[127:96] !== w.a22) report_mismatch("acc_22", m_axis_tdata[127:96], w.a22);
				if (m_axis_tdata[159:128] !== w.det) report_mismatch("det", m_axis_tdata[159:128], w.det);
				if (m_axis_tdata[191:160] !== w.vox) report_mismatch("vec_x", m_axis_tdata[191:160], w.vox);
				if (m_axis_tdata[223:192] !== w.voy) report_mismatch("vec_y", m_axis_tdata[223:192], w.voy);
				if (m_axis_tdata[FLAG_EXACT] !== w.ex) report_mismatch("exact", m_axis_tdata[224], w.ex);
				if (m_axis_tdata[FLAG_NEAR] !== w.nr) report_mismatch("near", m_axis_tdata[225], w.nr);
				if (m_axis_tdata[226] !== w.id) report_mismatch("identity", m_axis_tdata[226], w.id);
				if (m_axis_tdata[227] !== w.sg) report_mismatch("singular", m_axis_tdata[227], w.sg);
				if (m_axis_tdata[228] !== w.st) report_mismatch("saturated", m_axis_tdata[228], w.st);
			end
			beats_out++;
		end
		m_axis_tready <= hold_off == 0 && $urandom_range(99) >= recv_stall;
	end

	always @(posedge clk) if (hold_off > 0) hold_off <= hold_off - 1;

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(1) ? 32'(ONE) : -32'(ONE);
			3: return 32'($signed($urandom_range(8 * ONE)) - 4 * ONE);
			4: return $urandom_range(31) - 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_cmd(act_t a, logic [31:0] v11, v12, v21, v22, sc, vx, vy);
		cmd_t c;
		c.act = a;
		c.d = {vy, vx, sc, v22, v21, v12, v11};
		pending_cmds.push_back(c);
	endtask

	task automatic push_random(int n);
		logic [31:0] m11, m12, m21, m22;
		for (int i = 0; i < n; i++) begin
			m11 = rnd_val(); m12 = rnd_val(); m21 = rnd_val(); m22 = rnd_val();
			// near-copies of the accumulator as operand exercise the tolerance compare
			if ($urandom_range(3) == 0) begin
				m11 = mat[0] + $urandom_range(40) - 20; m12 = mat[1] + $urandom_range(40) - 20;
				m21 = mat[2] + $urandom_range(40) - 20; m22 = mat[3] + $urandom_range(40) - 20;
			end
			push_cmd(act_t'($urandom_range(15)), m11, m12, m21, m22, rnd_val(), rnd_val(),
				rnd_val());
		end
	endtask

	task automatic drain_and_write(logic [CFG_ADDR_W-1:0] idx, logic [15:0] v);
		while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_COORD_TOL) coord_tol = v; else det_tol = v;
	endtask

	initial begin
		logic [31:0] h;
		for (int i = 0; i < 4; i++) mat[i] = 0;
		coord_tol = 16; det_tol = 16;
		h = 32'(ONE);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		push_cmd(ACT_COMPARE, 0, 0, 0, 0, 0, h, h);
		push_cmd(ACT_INVERT, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(ACT_IDENTITY, h, 0, 0, h, 0, 32'h7fffffff, 32'h80000000);
		push_cmd(ACT_LOAD, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1, 0, h, h);
		push_cmd(ACT_ADD, 32'h7fffffff, 32'h80000000, 1, 32'h7fffffff, 0, 0, 0);
		push_cmd(ACT_SUB, 32'h80000000, 32'h7fffffff, 1, 5, 0, 0, 0);
		push_cmd(ACT_LOAD, 2 * h, h, h, 3 * h, 0, 0, 0);
		push_cmd(ACT_POSTMUL, h, 32'h8000, 32'hffff8000, h, 0, h, 0);
		push_cmd(ACT_PREMUL, 32'h7fffffff, 1, 1, 32'h80000000, 0, 0, 0);
		push_cmd(ACT_LOAD, 4 * h, 7 * h, 2 * h, 6 * h, 0, 0, 0);
		push_cmd(ACT_INVERT, 0, 0, 0, 0, 0, h, h);
		push_cmd(ACT_TRANSPOSE, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(ACT_SCALE, 0, 0, 0, 0, 32'h80000000, 0, 0);
		push_cmd(ACT_LOAD, 1, 1, 1, 1, 0, 0, 0);
		push_cmd(ACT_INVERT, 1, 1, 1, 1, 32'h7fffffff, 0, 0);
		push_cmd(ACT_LOAD, 3, 0, 0, 3, 0, 0, 0);
		push_cmd(ACT_INVERT, 20, 0, 0, 20, 0, 0, 0);
		push_cmd(ACT_VECTOR, 3, 0, 0, 3, 0, 32'h7fffffff, 32'h80000000);
		push_cmd(act_t'(4'd15), 0, 0, 0, 0, 0, 0, 0);
		// phase settings: no idling, sender slow, receiver slow, both, receiver hold-off, no idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 88; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 88; end
				3: begin send_idle = 38; recv_stall = 38; end
				4: begin send_idle = 0; recv_stall = 0; hold_off = 3000; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			case (ph)
				1: drain_and_write(REG_COORD_TOL, 0);
				2: drain_and_write(REG_DET_TOL, 0);
				3: drain_and_write(REG_COORD_TOL, 16'hffff);
				4: drain_and_write(REG_DET_TOL, 16'hffff);
				5: begin
					drain_and_write(REG_COORD_TOL, $urandom);
					drain_and_write(REG_DET_TOL, $urandom_range(100));
				end
				default: ;
			endcase
			push_random(150);
		end
		while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("%0d beats in, %0d beats out, all actions, four idling mixes,", beats_in,
			beats_out);
		$display("tolerance extremes and a long receiver hold-off");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
